@@ rtl/core/asymmetric_leaky_pid_step_unit_macros.svh @@
// Assertion macros used by the checker file of the PID step unit.
`ifndef ASYMMETRIC_LEAKY_PID_STEP_UNIT_MACROS_SVH
`define ASYMMETRIC_LEAKY_PID_STEP_UNIT_MACROS_SVH

// Same-cycle implication.
`define ALPID_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alpid assertion failed");

// Next-cycle implication.
`define ALPID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alpid assertion failed");

`endif

@@ rtl/core/alpid_pkg.sv @@
// Package with types, widths and codes of the PID step unit.
`timescale 1ns / 1ps
package alpid_pkg;

   localparam int ErrW     = 16;
   localparam int TimeW    = 16;
   localparam int GainW    = 16;
   localparam int LeakW    = 16;
   localparam int DriveW   = 32;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int MulAW    = 33;
   localparam int MulBW    = 18;
   localparam int ProdW    = MulAW + MulBW;
   localparam int DivW     = 40;
   localparam int DivCntW  = 6;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LEAK_FACTOR    = 3'd0,
      CSR_PROP_GAIN_POS  = 3'd1,
      CSR_INTEG_GAIN_POS = 3'd2,
      CSR_DERIV_GAIN_POS = 3'd3,
      CSR_PROP_GAIN_NEG  = 3'd4,
      CSR_INTEG_GAIN_NEG = 3'd5,
      CSR_DERIV_GAIN_NEG = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [LeakW-1:0]        leak_factor;
      logic signed [GainW-1:0] prop_gain_pos;
      logic signed [GainW-1:0] integ_gain_pos;
      logic signed [GainW-1:0] deriv_gain_pos;
      logic signed [GainW-1:0] prop_gain_neg;
      logic signed [GainW-1:0] integ_gain_neg;
      logic signed [GainW-1:0] deriv_gain_neg;
   } gains_type;

   typedef enum logic [2:0] {
      MUL_PROP,
      MUL_LEAK,
      MUL_KIE,
      MUL_ADD,
      MUL_DERIV
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROP,
      ST_LEAK,
      ST_KIE,
      ST_ADD,
      ST_INTEG,
      ST_DLOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        load_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        take_p;
      logic        take_leak;
      logic        take_integ;
      logic        div_init;
      logic        div_step;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/alpid_csr.sv @@
// Configuration register file: retention factor and the two gain sets.
`timescale 1ns / 1ps
module alpid_csr
   import alpid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data,
   output gains_type           gains
);

   gains_type gains_ff, gains_in;

   assign csr_ready = 1'b1;
   assign gains     = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LEAK_FACTOR:    gains_in.leak_factor    = csr_data;
            CSR_PROP_GAIN_POS:  gains_in.prop_gain_pos  = csr_data;
            CSR_INTEG_GAIN_POS: gains_in.integ_gain_pos = csr_data;
            CSR_DERIV_GAIN_POS: gains_in.deriv_gain_pos = csr_data;
            CSR_PROP_GAIN_NEG:  gains_in.prop_gain_neg  = csr_data;
            CSR_INTEG_GAIN_NEG: gains_in.integ_gain_neg = csr_data;
            CSR_DERIV_GAIN_NEG: gains_in.deriv_gain_neg = csr_data;
            default:            gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

@@ rtl/core/alpid_ctrl.sv @@
// Sequencer that steps the shared multiplier and the serial divider.
`timescale 1ns / 1ps
module alpid_ctrl
   import alpid_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [DivCntW-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.mul_sel = MUL_PROP;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_PROP;
            end
         end
         ST_PROP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PROP;
            state_in    = ST_LEAK;
         end
         ST_LEAK: begin
            cmd.take_p  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LEAK;
            state_in    = ST_KIE;
         end
         ST_KIE: begin
            cmd.take_leak = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_KIE;
            state_in      = ST_ADD;
         end
         ST_ADD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ADD;
            state_in    = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.take_integ = 1'b1;
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = MUL_DERIV;
            state_in       = ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DivCntW'(DivW - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/alpid_dp.sv @@
// Datapath: operand selection, shared multiplier, restoring divider and output word.
`timescale 1ns / 1ps
module alpid_dp
   import alpid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  gains_type         gains,
   input  logic [2*ErrW-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DriveW-1:0] rsp_tdata
);

   localparam int SumW  = DivW + 3;
   localparam int IntgW = 42;

   // Clamps a wide signed value into the drive range.
   function automatic logic [DriveW-1:0] sat_drive(input logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] hi;
      logic signed [SumW-1:0] lo;
      hi = SumW'(33'sh0_7FFF_FFFF);
      lo = -hi - SumW'(1);
      if (v > hi) begin
         sat_drive = {1'b0, {(DriveW-1){1'b1}}};
      end else if (v < lo) begin
         sat_drive = {1'b1, {(DriveW-1){1'b0}}};
      end else begin
         sat_drive = v[DriveW-1:0];
      end
   endfunction

   logic signed [ErrW-1:0]   err_ff, err_in;
   logic [TimeW-1:0]         dt_ff, dt_in;
   logic                     neg_ff, neg_in;
   logic signed [ErrW-1:0]   prev_ff, prev_in;
   logic signed [DriveW-1:0] integ_ff, integ_in;
   logic signed [ProdW-1:0]  prod_ff, prod_in;
   logic signed [DriveW-1:0] p_ff, p_in;
   logic signed [MulAW-1:0]  leak_ff, leak_in;
   logic [TimeW-1:0]         rem_ff, rem_in;
   logic [DivW-1:0]          quo_ff, quo_in;
   logic                     dneg_ff, dneg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DriveW-1:0]        rsp_data_ff, rsp_data_in;

   logic signed [GainW-1:0]  kp, ki, kd;
   logic signed [ErrW:0]     diff;
   logic signed [MulAW-1:0]  mul_a;
   logic signed [MulBW-1:0]  mul_b;
   logic signed [ProdW-1:0]  rnd_prod;
   logic signed [IntgW-1:0]  add_val;
   logic signed [IntgW-1:0]  integ_sum;
   logic [MulAW-1:0]         num_mag;
   logic [TimeW:0]           rem_sh;
   logic [TimeW+1:0]         trial;
   logic signed [DivW:0]     d_val;
   logic signed [SumW-1:0]   drive_sum;
   logic [SumW-1:0]          integ_sat_in;

   assign kp   = neg_ff ? gains.prop_gain_neg  : gains.prop_gain_pos;
   assign ki   = neg_ff ? gains.integ_gain_neg : gains.integ_gain_pos;
   assign kd   = neg_ff ? gains.deriv_gain_neg : gains.deriv_gain_pos;
   assign diff = {err_ff[ErrW-1], err_ff} - {prev_ff[ErrW-1], prev_ff};

   always_comb begin
      case (cmd.mul_sel)
         MUL_PROP: begin
            mul_a = {{(MulAW-GainW){kp[GainW-1]}}, kp};
            mul_b = {{(MulBW-ErrW){err_ff[ErrW-1]}}, err_ff};
         end
         MUL_LEAK: begin
            mul_a = {{(MulAW-DriveW){integ_ff[DriveW-1]}}, integ_ff};
            mul_b = {{(MulBW-LeakW){1'b0}}, gains.leak_factor};
         end
         MUL_KIE: begin
            mul_a = {{(MulAW-GainW){ki[GainW-1]}}, ki};
            mul_b = {{(MulBW-ErrW){err_ff[ErrW-1]}}, err_ff};
         end
         MUL_ADD: begin
            mul_a = {prod_ff[DriveW-1], prod_ff[DriveW-1:0]};
            mul_b = {{(MulBW-TimeW){1'b0}}, dt_ff};
         end
         MUL_DERIV: begin
            mul_a = {{(MulAW-GainW){kd[GainW-1]}}, kd};
            mul_b = {{(MulBW-ErrW-1){diff[ErrW]}}, diff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Leak rounds at bit 16, the integrator increment at bit 8; both floor after.
   always_comb begin
      if (cmd.take_leak) begin
         rnd_prod = prod_ff + ProdW'(1 << 15);
      end else begin
         rnd_prod = prod_ff + ProdW'(1 << 7);
      end
   end

   assign add_val      = rnd_prod[IntgW+7:8];
   assign integ_sum    = {{(IntgW-MulAW){leak_ff[MulAW-1]}}, leak_ff} + add_val;
   assign integ_sat_in = {{(SumW-IntgW){integ_sum[IntgW-1]}}, integ_sum};
   assign num_mag      = prod_ff[ProdW-1] ? (-prod_ff[MulAW-1:0]) : prod_ff[MulAW-1:0];
   assign rem_sh       = {rem_ff, quo_ff[DivW-1]};
   assign trial        = {1'b0, rem_sh} - {2'b0, dt_ff};

   // A zero timestep yields no derivative contribution.
   always_comb begin
      if (dt_ff == '0) begin
         d_val = '0;
      end else if (dneg_ff) begin
         d_val = -{1'b0, quo_ff};
      end else begin
         d_val = {1'b0, quo_ff};
      end
   end

   assign drive_sum = {{(SumW-DriveW){p_ff[DriveW-1]}}, p_ff}
                    + {{(SumW-DriveW){integ_ff[DriveW-1]}}, integ_ff}
                    + {{(SumW-DivW-1){d_val[DivW]}}, d_val};

   always_comb begin
      err_in       = err_ff;
      dt_in        = dt_ff;
      neg_in       = neg_ff;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      prod_in      = prod_ff;
      p_in         = p_ff;
      leak_in      = leak_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dneg_in      = dneg_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (cmd.load_in) begin
         err_in = req_tdata[ErrW-1:0];
         dt_in  = req_tdata[ErrW+TimeW-1:ErrW];
         neg_in = req_tdata[ErrW-1];
      end
      if (cmd.mul_en) begin
         prod_in = mul_a * mul_b;
      end
      if (cmd.take_p) begin
         p_in = prod_ff[DriveW-1:0];
      end
      if (cmd.take_leak) begin
         leak_in = rnd_prod[MulAW+15:16];
      end
      if (cmd.take_integ) begin
         integ_in = sat_drive(integ_sat_in);
      end
      if (cmd.div_init) begin
         dneg_in = prod_ff[ProdW-1];
         quo_in  = {num_mag[DriveW-1:0], 8'b0};
         rem_in  = '0;
         prev_in = err_ff;
      end
      if (cmd.div_step) begin
         if (!trial[TimeW+1]) begin
            rem_in = trial[TimeW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[TimeW-1:0];
            quo_in = {quo_ff[DivW-2:0], 1'b0};
         end
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sat_drive(drive_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      dt_ff       <= dt_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      p_ff        <= p_in;
      leak_ff     <= leak_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dneg_ff     <= dneg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.out_free = ~rsp_valid_ff | rsp_tready;

endmodule

@@ rtl/core/asymmetric_leaky_pid_step_unit.sv @@
// Top level of the asymmetric leaky PID step unit.
`timescale 1ns / 1ps
// The request channel carries one word per control step: the signed error and
// the Q8.8 timestep. The response channel returns one word, the saturated Q23.8
// drive value. The sign of the error picks the gain set for all three terms.
// The configuration channel writes the retention factor and the six gains and is
// always ready; the user must write only while no step is in flight (not enforced).
// Each word walks through one shared 33x18 multiplier (five products, one per
// cycle) and then a restoring divider that produces one quotient bit per cycle
// for the 40-bit derivative numerator. The response turns valid once the divider
// is done and the output register is free, as the unit goes back to idle, and only
// then is the next request taken. Most of a step is spent in the divider.
// The response sits in an output register; when the receiver stalls, the unit
// still accepts and computes the next word and holds its finished result until
// the output register frees up.
// Reset clears the integrator, the previous error, all configuration registers
// and the response valid flag; the unit is ready for a request right after it.
module asymmetric_leaky_pid_step_unit
   import alpid_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Request words.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [15:0] error_sample, [31:16] step_time
   // Response words.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DriveW-1:0]   rsp_tdata,   // [31:0] drive
   // Configuration writes.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data
);

   gains_type  gains;
   cmd_type    cmd;
   status_type status;

   alpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .gains     (gains)
   );

   // The sequencer only takes a request from its idle state.
   alpid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   alpid_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .gains      (gains),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/core/alpid_checker.sv @@
// Port-level checker for the PID step unit and its bind.
`timescale 1ns / 1ps
`include "asymmetric_leaky_pid_step_unit_macros.svh"
module alpid_checker
   import alpid_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DriveW-1:0] rsp_tdata
);

   logic req_take;

   assign req_take = req_tvalid & req_tready;

   // A stalled response word stays put.
   `ALPID_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                      rsp_tvalid && $stable(rsp_tdata))
   // Only one step is in flight: taking a word closes the request side.
   `ALPID_ASSERT_NEXT(a_one_in_flight, clock, reset, req_take, !req_tready)
   // A fresh result appears exactly as the unit goes back to idle.
   `ALPID_ASSERT_NOW(a_rsp_with_idle, clock, reset, $rose(rsp_tvalid), req_tready)
   // Reset leaves no response pending.
   `ALPID_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready)

endmodule

bind asymmetric_leaky_pid_step_unit alpid_checker u_alpid_checker (.*);
